FILE: src/tms_pkg.sv
// Shared types, constants and a helper function for the text markup stripper.
`timescale 1ns / 1ps
`default_nettype none

package tms_pkg;

  localparam int unsigned MAX_LENGTH    = 4096;
  localparam int unsigned STACK_DEPTH   = 10;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned NUM_STYLES    = 4;
  localparam int unsigned NUM_SLOTS     = 3 + NUM_STYLES;
  localparam int unsigned NUM_PAL_REGS  = 5;
  localparam int unsigned PAL_W         = 48;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned TPOS_W        = 13;
  localparam int unsigned MPOS_W        = 12;
  localparam int unsigned COLOR_W       = 24;
  localparam int unsigned NEST_W        = 8;
  localparam int unsigned SP_W          = $clog2(STACK_DEPTH);
  localparam int unsigned SLOT_W        = $clog2(NUM_SLOTS);

  localparam logic [NEST_W-1:0] NEST_MAX = '1;

  localparam logic [7:0] CH_FF = 8'h0C;
  localparam logic [7:0] CH_S  = 8'h73;
  localparam logic [7:0] CH_R  = 8'h72;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_LB = 8'h62;
  localparam logic [7:0] CH_UB = 8'h42;
  localparam logic [7:0] CH_LI = 8'h69;
  localparam logic [7:0] CH_UI = 8'h49;
  localparam logic [7:0] CH_LU = 8'h75;
  localparam logic [7:0] CH_UU = 8'h55;
  localparam logic [7:0] CH_LT = 8'h74;
  localparam logic [7:0] CH_UT = 8'h54;

  localparam logic [SLOT_W-1:0] SLOT_FIRST = SLOT_W'(0);
  localparam logic [SLOT_W-1:0] SLOT_CODE  = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] SLOT_COLOR = SLOT_W'(2);
  localparam logic [SLOT_W-1:0] SLOT_STYLE = SLOT_W'(3);

  typedef enum logic [2:0] {
    KIND_TEXT   = 3'd0,
    KIND_COLOR  = 3'd1,
    KIND_BOLD   = 3'd2,
    KIND_ITALIC = 3'd3,
    KIND_UNDER  = 3'd4,
    KIND_STRIKE = 3'd5,
    KIND_CODE   = 3'd6
  } kind_e;

  typedef logic [TPOS_W-1:0]  tpos_t;
  typedef logic [MPOS_W-1:0]  mpos_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [NUM_PAL_REGS-1:0][PAL_W-1:0] pal_regs_t;

  typedef struct packed {
    kind_e                       first_kind;
    logic [7:0]                  text_byte;
    tpos_t                       text_pos;
    mpos_t                       markup_pos;
    logic                        code_valid;
    kind_e                       code_kind;
    tpos_t                       code_start;
    tpos_t                       code_end;
    color_t                      code_color;
    logic                        last;
    logic                        color_valid;
    tpos_t                       color_start;
    color_t                      color_color;
    logic [NUM_STYLES-1:0]       style_valid;
    logic [NUM_STYLES-1:0][TPOS_W-1:0] style_start;
    tpos_t                       end_pos;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] text_byte;
    tpos_t      text_pos;
    mpos_t      markup_pos;
    tpos_t      span_start;
    tpos_t      span_end;
    color_t     span_color;
    tpos_t      stripped_length;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic full;
  } q_status_t;

  function automatic color_t pal_color(input pal_regs_t regs, input logic [3:0] idx);
    logic [2:0]       sel;
    logic [PAL_W-1:0] pair;
    sel = idx[3:1];
    if (sel >= 3'(NUM_PAL_REGS)) begin
      sel = sel - 3'(NUM_PAL_REGS);
    end
    pair = regs[sel];
    return idx[0] ? pair[2*COLOR_W-1:COLOR_W] : pair[COLOR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/tms_if.sv
// Valid/ready channel interfaces for markup bytes and stripper results.
`timescale 1ns / 1ps
`default_nettype none

interface tms_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] markup_byte;
  logic [23:0] base_color;
  logic       last_byte;

  modport source (output valid, markup_byte, base_color, last_byte, input ready);
  modport sink   (input valid, markup_byte, base_color, last_byte, output ready);
endinterface

interface tms_out_if import tms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          kind;
  logic [7:0]          text_byte;
  logic [TPOS_W-1:0]   text_pos;
  logic [MPOS_W-1:0]   markup_pos;
  logic [TPOS_W-1:0]   span_start;
  logic [TPOS_W-1:0]   span_end;
  logic [COLOR_W-1:0]  span_color;
  logic [TPOS_W-1:0]   stripped_length;
  logic                last_result;

  modport source (output valid, kind, text_byte, text_pos, markup_pos, span_start, span_end,
                  span_color, stripped_length, last_result, input ready);
  modport sink   (input valid, kind, text_byte, text_pos, markup_pos, span_start, span_end,
                  span_color, stripped_length, last_result, output ready);
endinterface

`default_nettype wire

FILE: src/tms_front.sv
// Front end: accepts markup bytes, tracks string state and builds one queue record per byte.
`timescale 1ns / 1ps
`default_nettype none

module tms_front import tms_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  tms_in_if.sink                     in_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [PAL_W-1:0]      cfg_data_i,
  input  wire q_status_t             q_status_i,
  output logic                       push_o,
  output item_t                      item_o
);

  pal_regs_t pal_q;

  logic   fresh_q, fresh_d;
  logic   esc_q, esc_d;
  tpos_t  tpos_q, tpos_d;
  mpos_t  mpos_q, mpos_d;
  color_t color_q, color_d;
  logic   cso_q, cso_d;
  tpos_t  cstart_q, cstart_d;
  logic [SP_W-1:0] sp_q, sp_d;
  logic [7:0]      top_q, top_d;
  logic [NUM_STYLES-1:0] sopen_q, sopen_d;
  tpos_t           sstart_q [NUM_STYLES];
  tpos_t           sstart_d [NUM_STYLES];
  logic [NEST_W-1:0] nest_q [NUM_STYLES];
  logic [NEST_W-1:0] nest_d [NUM_STYLES];

  logic [7:0] stack_q [STACK_DEPTH];
  logic            stk_we;
  logic [SP_W-1:0] stk_wa;
  logic [7:0]      stk_wd;
  logic [SP_W-1:0] stk_ra;

  logic   e_esc, e_cso;
  tpos_t  e_tpos, e_cstart;
  mpos_t  e_mpos;
  color_t e_color;
  logic [SP_W-1:0] e_sp;
  logic [7:0]      e_top;
  logic [NUM_STYLES-1:0] e_sopen;
  logic [NEST_W-1:0] e_nest [NUM_STYLES];

  logic [7:0] b;
  logic       is_code, is_ff, is_text;
  logic       is_style, s_opens;
  logic [1:0] sidx;
  logic [7:0] v;
  color_t     newc;
  logic [NEST_W-1:0] nest_dec;
  item_t      item;

  assign in_i.ready = !q_status_i.full;
  assign push_o     = in_i.valid && in_i.ready;
  assign item_o     = item;
  assign b          = in_i.markup_byte;

  always_comb begin
    e_esc    = fresh_q ? 1'b0 : esc_q;
    e_tpos   = fresh_q ? '0 : tpos_q;
    e_mpos   = fresh_q ? '0 : mpos_q;
    e_color  = fresh_q ? in_i.base_color : color_q;
    e_cso    = fresh_q ? 1'b1 : cso_q;
    e_cstart = fresh_q ? '0 : cstart_q;
    e_sp     = fresh_q ? '0 : sp_q;
    e_top    = fresh_q ? '0 : top_q;
    e_sopen  = fresh_q ? '0 : sopen_q;
    for (int k = 0; k < NUM_STYLES; k++) begin
      e_nest[k] = fresh_q ? '0 : nest_q[k];
    end
  end

  always_comb begin
    is_style = 1'b1;
    s_opens  = 1'b0;
    sidx     = 2'd0;
    unique case (b)
      CH_LB: begin sidx = 2'd0; s_opens = 1'b1; end
      CH_UB: begin sidx = 2'd0; end
      CH_LI: begin sidx = 2'd1; s_opens = 1'b1; end
      CH_UI: begin sidx = 2'd1; end
      CH_LU: begin sidx = 2'd2; s_opens = 1'b1; end
      CH_UU: begin sidx = 2'd2; end
      CH_LT: begin sidx = 2'd3; s_opens = 1'b1; end
      CH_UT: begin sidx = 2'd3; end
      default: is_style = 1'b0;
    endcase
  end

  assign stk_ra = (e_sp != '0) ? e_sp - SP_W'(1) : '0;

  always_comb begin
    is_code = e_esc;
    is_ff   = !e_esc && (b == CH_FF) && !in_i.last_byte;
    is_text = !is_code && !is_ff;

    esc_d    = 1'b0;
    tpos_d   = e_tpos;
    mpos_d   = (e_mpos != mpos_t'(MAX_LENGTH - 1)) ? e_mpos + mpos_t'(1) : e_mpos;
    color_d  = e_color;
    cso_d    = e_cso;
    cstart_d = e_cstart;
    sp_d     = e_sp;
    top_d    = e_top;
    sopen_d  = e_sopen;
    for (int k = 0; k < NUM_STYLES; k++) begin
      sstart_d[k] = sstart_q[k];
      nest_d[k]   = e_nest[k];
    end
    fresh_d  = 1'b0;

    stk_we   = fresh_q;
    stk_wa   = '0;
    stk_wd   = '0;
    v        = '0;
    newc     = in_i.base_color;
    nest_dec = '0;

    item             = '0;
    item.first_kind  = is_text ? KIND_TEXT : KIND_CODE;
    item.text_byte   = is_text ? b : 8'd0;
    item.text_pos    = e_tpos;
    item.markup_pos  = e_mpos;
    item.code_kind   = KIND_COLOR;

    if (is_code) begin
      if (is_style) begin
        if (s_opens) begin
          if (!e_sopen[sidx]) begin
            sopen_d[sidx]  = 1'b1;
            sstart_d[sidx] = e_tpos;
          end
          if (e_nest[sidx] != NEST_MAX) begin
            nest_d[sidx] = e_nest[sidx] + NEST_W'(1);
          end
        end else if (e_sopen[sidx]) begin
          nest_dec = (e_nest[sidx] != '0) ? e_nest[sidx] - NEST_W'(1) : e_nest[sidx];
          nest_d[sidx] = nest_dec;
          if (nest_dec == '0) begin
            item.code_valid = 1'b1;
            item.code_kind  = kind_e'(3'(KIND_BOLD) + 3'(sidx));
            item.code_start = sstart_q[sidx];
            item.code_end   = e_tpos;
            sopen_d[sidx]   = 1'b0;
          end
        end
      end else begin
        if (b == CH_S) begin
          v = e_top;
          if (32'(e_sp) + 32'd1 < 32'(STACK_DEPTH)) begin
            sp_d   = e_sp + SP_W'(1);
            stk_we = 1'b1;
            stk_wa = e_sp + SP_W'(1);
            stk_wd = e_top;
          end
        end else begin
          if (b == CH_R) begin
            sp_d  = stk_ra;
            v     = stack_q[stk_ra];
            top_d = v;
          end else begin
            stk_we = 1'b1;
            stk_wa = e_sp;
            stk_wd = b;
            top_d  = b;
            v      = b;
          end
          if (v >= CH_0 && v <= CH_9) begin
            newc = pal_color(pal_q, 4'(v - CH_0));
          end
        end
        if (e_cso) begin
          item.code_valid = 1'b1;
          item.code_kind  = KIND_COLOR;
          item.code_start = e_cstart;
          item.code_end   = e_tpos + tpos_t'(1);
          item.code_color = e_color;
          cso_d           = 1'b0;
        end
        color_d = newc;
      end
    end else if (is_ff) begin
      esc_d = 1'b1;
    end else begin
      if (!e_cso) begin
        cso_d    = 1'b1;
        cstart_d = e_tpos;
      end
      if (e_tpos < tpos_t'(MAX_LENGTH)) begin
        tpos_d = e_tpos + tpos_t'(1);
      end
    end

    item.last        = in_i.last_byte;
    item.color_valid = cso_d;
    item.color_start = cstart_d;
    item.color_color = color_d;
    item.style_valid = sopen_d;
    for (int k = 0; k < NUM_STYLES; k++) begin
      item.style_start[k] = sstart_d[k];
    end
    item.end_pos     = tpos_d;

    if (in_i.last_byte) begin
      cso_d   = 1'b0;
      sopen_d = '0;
      esc_d   = 1'b0;
      fresh_d = 1'b1;
      for (int k = 0; k < NUM_STYLES; k++) begin
        nest_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= '1;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_PAL_REGS))) begin
      pal_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q  <= 1'b1;
      esc_q    <= 1'b0;
      tpos_q   <= '0;
      mpos_q   <= '0;
      color_q  <= '0;
      cso_q    <= 1'b0;
      cstart_q <= '0;
      sp_q     <= '0;
      top_q    <= '0;
      sopen_q  <= '0;
      for (int k = 0; k < NUM_STYLES; k++) begin
        sstart_q[k] <= '0;
        nest_q[k]   <= '0;
      end
    end else if (push_o) begin
      fresh_q  <= fresh_d;
      esc_q    <= esc_d;
      tpos_q   <= tpos_d;
      mpos_q   <= mpos_d;
      color_q  <= color_d;
      cso_q    <= cso_d;
      cstart_q <= cstart_d;
      sp_q     <= sp_d;
      top_q    <= top_d;
      sopen_q  <= sopen_d;
      for (int k = 0; k < NUM_STYLES; k++) begin
        sstart_q[k] <= sstart_d[k];
        nest_q[k]   <= nest_d[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_o && stk_we) begin
      stack_q[stk_wa] <= stk_wd;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sp_q) < 32'(STACK_DEPTH))
    else $error("Color stack pointer ran past the stack depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && in_i.last_byte |=> fresh_q && !esc_q && (sopen_q == '0) && !cso_q)
    else $error("String state was not closed after the final byte.");

endmodule

`default_nettype wire

FILE: src/tms_queue.sv
// Short record queue between the front end and the result expander.
`timescale 1ns / 1ps
`default_nettype none

module tms_queue import tms_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  input  wire logic  pop_i,
  output q_status_t  status_o,
  output logic       head_valid_o,
  output item_t      head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d;
  logic [PTR_W-1:0]  rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  assign status_o.full = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign head_valid_o  = (cnt_q != '0);
  assign head_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && cnt_q == '0) && !(push_i && cnt_q == CNT_W'(QUEUE_DEPTH)))
    else $error("Queue overflow or underflow.");

endmodule

`default_nettype wire

FILE: src/tms_back.sv
// Back end: expands each queued record into its results, one transfer per cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module tms_back import tms_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  head_valid_i,
  input  wire item_t head_i,
  output logic       pop_o,
  tms_out_if.source  out_o
);

  logic [NUM_SLOTS-1:0] done_q, done_d;
  logic [NUM_SLOTS-1:0] pend, rem, pick, after;
  logic [SLOT_W-1:0]    slot;
  logic [1:0]           sk;
  logic                 found, is_last, load;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q, res;

  always_comb begin
    pend[0] = 1'b1;
    pend[1] = head_i.code_valid;
    pend[2] = head_i.last && head_i.color_valid;
    for (int k = 0; k < NUM_STYLES; k++) begin
      pend[3+k] = head_i.last && head_i.style_valid[k];
    end
    rem   = pend & ~done_q;
    pick  = '0;
    slot  = '0;
    found = 1'b0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (rem[s] && !found) begin
        found   = 1'b1;
        pick[s] = 1'b1;
        slot    = SLOT_W'(s);
      end
    end
    after   = rem & ~pick;
    is_last = (after == '0);
    load    = head_valid_i && (!out_valid_q || out_o.ready);
    pop_o   = load && is_last;
    done_d  = done_q;
    if (load) begin
      done_d = is_last ? '0 : (done_q | pick);
    end
    out_valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_comb begin
    sk              = 2'(slot - SLOT_STYLE);
    res             = '0;
    res.text_pos    = head_i.text_pos;
    res.markup_pos  = head_i.markup_pos;
    res.last_result = is_last;
    res.stripped_length = (is_last && head_i.last) ? head_i.end_pos : '0;
    case (slot)
      SLOT_FIRST: begin
        res.kind      = head_i.first_kind;
        res.text_byte = head_i.text_byte;
      end
      SLOT_CODE: begin
        res.kind       = head_i.code_kind;
        res.span_start = head_i.code_start;
        res.span_end   = head_i.code_end;
        res.span_color = head_i.code_color;
      end
      SLOT_COLOR: begin
        res.kind       = KIND_COLOR;
        res.span_start = head_i.color_start;
        res.span_end   = head_i.end_pos;
        res.span_color = head_i.color_color;
      end
      default: begin
        res.kind       = kind_e'(3'(KIND_BOLD) + 3'(sk));
        res.span_start = head_i.style_start[sk];
        res.span_end   = head_i.end_pos;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.kind            = out_q.kind;
  assign out_o.text_byte       = out_q.text_byte;
  assign out_o.text_pos        = out_q.text_pos;
  assign out_o.markup_pos      = out_q.markup_pos;
  assign out_o.span_start      = out_q.span_start;
  assign out_o.span_end        = out_q.span_end;
  assign out_o.span_color      = out_q.span_color;
  assign out_o.stripped_length = out_q.stripped_length;
  assign out_o.last_result     = out_q.last_result;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> (rem != '0))
    else $error("Queue head has no result left to send.");

endmodule

`default_nettype wire

FILE: src/text_markup_stripper_top.sv
// Top level of the text markup stripper: front end, record queue and result expander.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one markup byte per cycle while its four-entry record queue has room and
// turns each byte into one to six results, which leave through a registered output at one
// transfer per cycle while the receiver is ready. A byte that yields a single result then
// sustains one byte per cycle; a byte that yields several results occupies the output for
// one transfer per result, and the queue soaks up the burst of span closes at the end of a
// string. The first result of a byte passes through the record queue and then the output
// register before it is presented. Palette registers reset to white. The user must write
// them through the plain write port while idle; the block itself does not enforce it.
module text_markup_stripper_top import tms_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  tms_in_if.sink                    in_i,
  tms_out_if.source                 out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [PAL_W-1:0]     cfg_data_i
);

  q_status_t q_status;
  logic      push;
  item_t     item;
  logic      head_valid;
  item_t     head;
  logic      pop;

  tms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .item_o     (item)
  );

  tms_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item),
    .pop_i        (pop),
    .status_o     (q_status),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  tms_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
